>>> rtl/core/sbglm_pkg.sv
// Package for the level meter: widths, reset values, register indexes and payload types.
package sbglm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LVL_W      = 3;
  localparam int DUTY_W     = 8;
  localparam int MARGIN_W   = 10;
  localparam int LEDS       = 5;
  localparam int WINDOW_DEF = 3;

  localparam int FULL_SCALE = 4095;
  localparam int SPAN_SHIFT = 12;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;
  localparam logic [LVL_W-1:0]  LEVEL_NONE = 3'd7;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = 10'd20;
  localparam logic [SAMPLE_W-1:0] CUTOFF_RST = 12'd50;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_CUTOFF  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                restart;
  } sbglm_in_t;

  typedef struct packed {
    logic              ready_res;
    logic              updated;
    logic [LEDS-1:0]   lit_mask;
    logic [DUTY_W-1:0] duty;
    logic [LVL_W-1:0]  bar_level;
  } sbglm_out_t;

  typedef struct packed {
    logic                display_mode;
    logic [MARGIN_W-1:0] level_margin;
    logic [SAMPLE_W-1:0] dark_cutoff;
  } sbglm_cfg_t;

  typedef struct packed {
    logic                full;
    logic [SAMPLE_W-1:0] mean;
  } sbglm_mean_t;

endpackage

>>> rtl/core/smoothed_bar_graph_level_meter_top.sv
// Top level of the smoothed bar-graph level meter: channels, config registers, stage registers.
//
// Input channel in_valid/in_ready/in_data carries one sensor sample and a restart flag per
// transaction. Result channel out_valid/out_ready/out_data returns exactly one result per
// sample: ready flag, update flag, held LED mask and duty, and the current bar level.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes display_mode (0),
// level_margin (1) and dark_cutoff (2); other indexes are dropped. cfg_ready is always high.
// Write configuration only while no sample is in flight.
//
// A sample accepted at the input is registered, evaluated by a single pass through the
// window sum, reciprocal-multiply mean and display decision, and lands in the result register
// when that register is free or being drained. One sample per cycle is sustained while
// the receiver keeps out_ready high. When the receiver stalls, the result register holds and
// the stage register keeps one more sample; in_ready drops only while both are occupied.
// Synchronous reset empties both stages, clears the window fill and level memory, turns
// all LEDs off, sets duty to full scale and loads the register defaults.
module smoothed_bar_graph_level_meter_top
  import sbglm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sbglm_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sbglm_out_t            out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                s1_valid_r, s1_valid_nxt;
  sbglm_in_t           s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  sbglm_out_t          out_data_r;
  logic                s1_fire;
  logic                in_fire;
  logic                mode_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [SAMPLE_W-1:0] cutoff_r;
  sbglm_cfg_t          cfg;
  sbglm_mean_t         mean;
  sbglm_out_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      margin_r <= MARGIN_RST;
      cutoff_r <= CUTOFF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DISPLAY_MODE: mode_r   <= cfg_data[0];
        CFG_LEVEL_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
        CFG_DARK_CUTOFF:  cutoff_r <= cfg_data[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.display_mode = mode_r;
  assign cfg.level_margin = margin_r;
  assign cfg.dark_cutoff  = cutoff_r;

  // advance the stage whenever the result register is free or being drained
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  sbglm_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .sample  (s1_item_r.sample),
    .restart (s1_item_r.restart),
    .mean_o  (mean)
  );

  sbglm_decide u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (s1_fire),
    .restart (s1_item_r.restart),
    .mean_i  (mean),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without both stages occupied by a blocked result");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r)
    else $error("staged sample dropped while the result was stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("evaluated sample produced no result");

endmodule

>>> rtl/core/sbglm_window.sv
// Sample window: circular storage, fill tracking, sum and mean by reciprocal multiply.
module sbglm_window
  import sbglm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                restart,
  output sbglm_mean_t         mean_o
);

  localparam int PW     = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + PW;
  localparam int SHIFT  = SUM_W + PW;
  localparam int RW     = SHIFT + 1;
  localparam int PROD_W = SUM_W + RW;
  // ceil(2^SHIFT / WINDOW) gives an exact quotient for every sum below 2^SUM_W
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic [SAMPLE_W-1:0] win_r [WINDOW];
  logic [PW-1:0]       wpos_r, wpos_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt, fill_eff;
  logic [SUM_W-1:0]    sum;
  logic [PROD_W-1:0]   prod;

  // sum includes the incoming sample in place of the slot it overwrites
  always_comb begin
    sum = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (PW'(i) == wpos_r) begin
        sum = sum + SUM_W'(sample);
      end else begin
        sum = sum + SUM_W'(win_r[i]);
      end
    end
  end

  assign prod = PROD_W'(sum) * PROD_W'(RECIP);

  always_comb begin
    fill_eff = restart ? '0 : fill_r;
    fill_nxt = (fill_eff < FILL_W'(WINDOW)) ? fill_eff + 1'b1 : fill_eff;
    wpos_nxt = (wpos_r == PW'(WINDOW - 1)) ? '0 : wpos_r + 1'b1;
  end

  assign mean_o.full = (fill_nxt == FILL_W'(WINDOW));
  assign mean_o.mean = prod[SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (fire) begin
      win_r[wpos_r] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
      fill_r <= '0;
    end else if (fire) begin
      wpos_r <= wpos_nxt;
      fill_r <= fill_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("window fill count beyond window depth");

  a_restart_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fire && restart |=> fill_r == FILL_W'(1))
    else $error("restart did not leave exactly one sample in the window");

endmodule

>>> rtl/core/sbglm_decide.sv
// Display decision: level with hysteresis, brightness duty and the held LED pattern.
module sbglm_decide
  import sbglm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        restart,
  input  sbglm_mean_t mean_i,
  input  sbglm_cfg_t  cfg_i,
  output sbglm_out_t  res_o
);

  localparam int LP_W = SAMPLE_W + LVL_W;
  localparam int CMP_W = SAMPLE_W + 1;
  localparam int DX_W = SAMPLE_W + DUTY_W;

  typedef logic [SAMPLE_W-1:0] bound_tbl_t [2**LVL_W];

  function automatic bound_tbl_t build_bounds();
    bound_tbl_t t;
    for (int k = 0; k < 2**LVL_W; k++) begin
      t[k] = (k <= LEDS + 1) ? SAMPLE_W'(k * FULL_SCALE / (LEDS + 1)) : '0;
    end
    return t;
  endfunction

  localparam bound_tbl_t BOUND_TBL = build_bounds();

  function automatic logic [LEDS-1:0] lower_mask(input logic [LVL_W-1:0] lvl);
    logic [LEDS-1:0] m;
    for (int i = 0; i < LEDS; i++) begin
      m[i] = (LVL_W'(i) < lvl);
    end
    return m;
  endfunction

  logic [LVL_W-1:0]  last_r, last_nxt, last_eff;
  logic              known_r, known_nxt, known_eff;
  logic [LEDS-1:0]   lit_r, lit_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;

  logic [LP_W-1:0]     lvl_prod;
  logic [LVL_W-1:0]    level;
  logic [SAMPLE_W-1:0] bound_hi, bound_lo;
  logic                take_up, take_dn, take;
  logic [SAMPLE_W-1:0] m_gated;
  logic [DX_W-1:0]     dx;
  logic [CMP_W-1:0]    dsum;
  logic [DUTY_W:0]     dq;
  logic                updated;

  assign known_eff = restart ? 1'b0 : known_r;
  assign last_eff  = restart ? LEVEL_NONE : last_r;

  assign lvl_prod = LP_W'(mean_i.mean) * LP_W'(LEDS + 1);
  assign level    = lvl_prod[SPAN_SHIFT +: LVL_W];

  assign bound_hi = BOUND_TBL[LVL_W'(last_eff + 1'b1)];
  assign bound_lo = BOUND_TBL[last_eff];
  assign take_up  = {1'b0, mean_i.mean} > ({1'b0, bound_hi} + CMP_W'(cfg_i.level_margin));
  assign take_dn  = ({1'b0, mean_i.mean} + CMP_W'(cfg_i.level_margin)) < {1'b0, bound_lo};

  // duty = m*255/4095: x = 4096a + b, quotient is a, plus one when a + b reaches 4095
  assign m_gated = (mean_i.mean <= cfg_i.dark_cutoff) ? '0 : mean_i.mean;
  assign dx      = {m_gated, {DUTY_W{1'b0}}} - DX_W'(m_gated);
  assign dsum    = CMP_W'(dx[DX_W-1 -: DUTY_W]) + CMP_W'(dx[SAMPLE_W-1:0]);
  assign dq      = (DUTY_W + 1)'(dx[DX_W-1 -: DUTY_W])
                 + (DUTY_W + 1)'(dsum >= CMP_W'(FULL_SCALE));

  always_comb begin
    last_nxt  = last_eff;
    known_nxt = known_eff;
    lit_nxt   = lit_r;
    duty_nxt  = duty_r;
    updated   = 1'b0;
    take      = 1'b0;
    if (mean_i.full) begin
      if (cfg_i.display_mode) begin
        lit_nxt   = '1;
        duty_nxt  = dq[DUTY_W-1:0];
        known_nxt = 1'b0;
        last_nxt  = LEVEL_NONE;
        updated   = 1'b1;
      end else if (!known_eff || level != last_eff) begin
        if (!known_eff) begin
          take = 1'b1;
        end else if (level > last_eff) begin
          take = take_up;
        end else begin
          take = take_dn;
        end
        if (take) begin
          lit_nxt   = lower_mask(level);
          duty_nxt  = DUTY_MAX;
          last_nxt  = level;
          known_nxt = 1'b1;
          updated   = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.ready_res = mean_i.full;
    res_o.updated   = updated;
    res_o.lit_mask  = lit_nxt;
    res_o.duty      = duty_nxt;
    res_o.bar_level = mean_i.full ? level : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= LEVEL_NONE;
      known_r <= 1'b0;
      lit_r   <= '0;
      duty_r  <= DUTY_MAX;
    end else if (fire) begin
      last_r  <= last_nxt;
      known_r <= known_nxt;
      lit_r   <= lit_nxt;
      duty_r  <= duty_nxt;
    end
  end

endmodule
